// File: hw/rtl/overcurrent_step_limiter_unit_defines.svh
// Assertion macros shared by the overcurrent step limiter checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef OVERCURRENT_STEP_LIMITER_UNIT_DEFINES_SVH
`define OVERCURRENT_STEP_LIMITER_UNIT_DEFINES_SVH

// Plain property check, clocked on the rising edge, off while in reset.
`define OSL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled word must keep its payload until it is taken.
`define OSL_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// File: hw/rtl/osl_pkg.sv
// Package for the overcurrent step limiter: types, register indexes, reset values
// and the command scaling function. No dependencies.
package osl_pkg;

    // Limit levels
    typedef enum logic [1:0] {
        LVL_FULL    = 2'd0,
        LVL_HALF    = 2'd1,
        LVL_QUARTER = 2'd2,
        LVL_OFF     = 2'd3
    } t_level;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_PERIOD = 1'd1;

    // Field widths
    localparam int CUR_W    = 16;
    localparam int LIMIT_W  = 16;
    localparam int PERIOD_W = 10;
    localparam int CNT_W    = 12;
    localparam int IDX_W    = 2;

    // Reset values and defaults
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd16384;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;
    localparam int MOTOR_COUNT_DEFAULT = 4;

    // Live configuration handed to the motor bank
    typedef struct packed {
        logic [LIMIT_W-1:0]  trip_limit;
        logic [PERIOD_W-1:0] dwell_period;
    } t_cfg;

    // Scale a command by the level; divisions truncate toward zero
    function automatic logic signed [CUR_W-1:0] osl_scale(
        input logic signed [CUR_W-1:0] cmd,
        input t_level                  lvl
    );
        logic signed [CUR_W:0] ext;
        logic signed [CUR_W:0] half_v;
        logic signed [CUR_W:0] quarter_v;
        logic signed [CUR_W-1:0] res;
        ext       = {cmd[CUR_W-1], cmd};
        // add divisor-1 to negative values so the arithmetic shift rounds toward zero
        half_v    = (ext + (cmd[CUR_W-1] ? 17'sd1 : 17'sd0)) >>> 1;
        quarter_v = (ext + (cmd[CUR_W-1] ? 17'sd3 : 17'sd0)) >>> 2;
        case (lvl)
            LVL_FULL:    res = cmd;
            LVL_HALF:    res = half_v[CUR_W-1:0];
            LVL_QUARTER: res = quarter_v[CUR_W-1:0];
            default:     res = '0;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/osl_motor_bank.sv
// Per-motor limit level and hysteresis counter with the single-pass update logic.
// Depends on osl_pkg.
module osl_motor_bank #(
    parameter int MOTOR_COUNT = osl_pkg::MOTOR_COUNT_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_upd,
    input  logic [osl_pkg::IDX_W-1:0]           i_motor_index,
    input  logic signed [osl_pkg::CUR_W-1:0]    i_measured_current,
    input  logic signed [osl_pkg::CUR_W-1:0]    i_commanded_current,
    input  osl_pkg::t_cfg                       i_cfg,
    output logic signed [osl_pkg::CUR_W-1:0]    o_limited_current,
    output osl_pkg::t_level                     o_limit_level
);

    localparam int CNT_W = osl_pkg::CNT_W;

    osl_pkg::t_level               r_level [MOTOR_COUNT];
    logic signed [CNT_W-1:0]       r_count [MOTOR_COUNT];

    logic                          hit;
    osl_pkg::t_level               cur_lvl;
    logic signed [CNT_W-1:0]       cur_cnt;
    logic [osl_pkg::CUR_W:0]       mag;
    logic signed [CNT_W-1:0]       per_s;
    logic signed [CNT_W-1:0]       n_cnt;
    osl_pkg::t_level               n_lvl;

    // Read the addressed motor's state
    always_comb begin
        hit     = 1'b0;
        cur_lvl = osl_pkg::LVL_FULL;
        cur_cnt = '0;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (int'(i_motor_index) == i) begin
                hit     = 1'b1;
                cur_lvl = r_level[i];
                cur_cnt = r_count[i];
            end
        end
    end

    // Absolute current, 17 bits so full-scale negative does not wrap
    assign mag   = i_measured_current[osl_pkg::CUR_W-1]
                   ? (~{1'b1, i_measured_current} + 17'd1)
                   : {1'b0, i_measured_current};
    assign per_s = $signed({{(CNT_W-osl_pkg::PERIOD_W){1'b0}}, i_cfg.dwell_period});

    // Hysteresis step
    always_comb begin
        n_lvl = cur_lvl;
        if (mag > {1'b0, i_cfg.trip_limit}) begin
            if (cur_lvl == osl_pkg::LVL_FULL) begin
                n_lvl = osl_pkg::LVL_HALF;
            end
            n_cnt = cur_cnt + 12'sd1;
            if (n_cnt > per_s) begin
                if (n_lvl != osl_pkg::LVL_OFF) begin
                    n_lvl = osl_pkg::t_level'(n_lvl + 2'd1);
                end
                n_cnt = '0;
            end
        end else begin
            n_cnt = cur_cnt - 12'sd1;
            if (n_cnt < -per_s) begin
                if (n_lvl != osl_pkg::LVL_FULL) begin
                    n_lvl = osl_pkg::t_level'(n_lvl - 2'd1);
                end
                n_cnt = '0;
            end
        end
    end

    // Write back the addressed motor
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            if (!i_rst_n) begin
                r_level[i] <= osl_pkg::LVL_FULL;
                r_count[i] <= '0;
            end else if (i_upd && int'(i_motor_index) == i) begin
                r_level[i] <= n_lvl;
                r_count[i] <= n_cnt;
            end
        end
    end

    // Result; an unknown motor reads as off with no drive
    assign o_limit_level     = hit ? n_lvl : osl_pkg::LVL_OFF;
    assign o_limited_current = hit ? osl_pkg::osl_scale(i_commanded_current, n_lvl) : '0;

endmodule

// File: hw/rtl/overcurrent_step_limiter_unit.sv
// Overcurrent step limiter top level: input register, motor bank, result register.
// Depends on osl_pkg and osl_motor_bank.
//
// Usage:
//  - Input words (motor index, measured current, commanded current) arrive on
//    i_in_valid / o_in_ready; results (limited current, limit level) leave on
//    o_out_valid / i_out_ready. Every input word yields exactly one result word.
//  - An accepted word waits in the input register, then enters the result register
//    once that slot is free or draining. Throughput is one word per cycle while
//    results drain, set by the level/counter read-modify-write between the registers.
//  - Configuration writes use i_cfg_valid / o_cfg_ready with i_cfg_index
//    (0 current limit, 1 hysteresis period) and i_cfg_data; o_cfg_ready is
//    always high. Write only while no word is in flight.
//  - Synchronous active-low reset puts every motor at full level with a zero
//    counter and loads limit 16384, period 100.
//  - When the receiver stalls the result word holds; one more word waits in the
//    input register, then o_in_ready drops until the result is taken.
module overcurrent_step_limiter_unit #(
    parameter int MOTOR_COUNT = osl_pkg::MOTOR_COUNT_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [osl_pkg::IDX_W-1:0]           i_motor_index,
    input  logic signed [osl_pkg::CUR_W-1:0]    i_measured_current,
    input  logic signed [osl_pkg::CUR_W-1:0]    i_commanded_current,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [osl_pkg::CUR_W-1:0]    o_limited_current,
    output logic [1:0]                          o_limit_level,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [osl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [osl_pkg::LIMIT_W-1:0]         i_cfg_data
);

    logic                               r_in_vld;
    logic [osl_pkg::IDX_W-1:0]          r_idx;
    logic signed [osl_pkg::CUR_W-1:0]   r_meas;
    logic signed [osl_pkg::CUR_W-1:0]   r_cmd;
    logic                               r_out_vld;
    logic signed [osl_pkg::CUR_W-1:0]   r_res;
    osl_pkg::t_level                    r_lvl;
    osl_pkg::t_cfg                      r_cfg;

    logic                               adv;
    logic                               in_acc;
    logic signed [osl_pkg::CUR_W-1:0]   n_res;
    osl_pkg::t_level                    n_lvl;

    // Handshake: move a word forward when the result slot is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trip_limit   <= osl_pkg::LIMIT_RESET;
            r_cfg.dwell_period <= osl_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                osl_pkg::REG_CURRENT_LIMIT:
                    r_cfg.trip_limit <= i_cfg_data;
                osl_pkg::REG_HYSTERESIS_PERIOD:
                    r_cfg.dwell_period <= i_cfg_data[osl_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx  <= i_motor_index;
            r_meas <= i_measured_current;
            r_cmd  <= i_commanded_current;
        end
    end

    osl_motor_bank #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_bank (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_upd               (adv),
        .i_motor_index       (r_idx),
        .i_measured_current  (r_meas),
        .i_commanded_current (r_cmd),
        .i_cfg               (r_cfg),
        .o_limited_current   (n_res),
        .o_limit_level       (n_lvl)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
            r_lvl <= n_lvl;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_limited_current = r_res;
    assign o_limit_level     = r_lvl;

endmodule

// File: hw/rtl/osl_checker.sv
// Port-level checker for the overcurrent step limiter, bound to the top level.
// Depends on osl_pkg and overcurrent_step_limiter_unit_defines.svh.
`include "overcurrent_step_limiter_unit_defines.svh"

module osl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [osl_pkg::CUR_W-1:0]    o_limited_current,
    input logic [1:0]                          o_limit_level,
    input logic                                o_cfg_ready
);

    // An empty result slot means the block can always take a word
    `OSL_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with empty output")

    // Off level never drives current
    `OSL_ASSERT(a_off_zero, i_clk, i_rst_n, (o_out_valid && o_limit_level == osl_pkg::LVL_OFF) |-> (o_limited_current == '0), "nonzero current at off level")

    // Configuration port never back-pressures
    `OSL_ASSERT(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready, "configuration port not ready")

    // A stalled result word keeps its payload
    `OSL_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_ready, {o_limited_current, o_limit_level}, "result changed while stalled")

endmodule

bind overcurrent_step_limiter_unit osl_checker u_osl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_limited_current (o_limited_current),
    .o_limit_level     (o_limit_level),
    .o_cfg_ready       (o_cfg_ready)
);
